// ----- sv/ppst_pkg.sv -----
`default_nettype none
package ppst_pkg;
	localparam int MAX_WAYPOINTS = 256;
	localparam int CORDIC_STEPS = 16;
	localparam int IDX_W = $clog2(MAX_WAYPOINTS);
	localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int CW = 48;
	localparam int ZW = 20;
	localparam int DVD_W = 48;
	localparam int DVS_W = 33;

	localparam logic [1:0] CFG_LOOKAHEAD = 2'd0;
	localparam logic [1:0] CFG_MAX_LIN = 2'd1;
	localparam logic [1:0] CFG_MAX_ANG = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_CLEARED = 3'd2;
	localparam logic [2:0] ST_STORED = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	localparam logic signed [ZW-1:0] PI16 = 20'sd205887;
	localparam logic signed [ZW-1:0] HALF_PI16 = 20'sd102944;
	localparam logic signed [17:0] PI13 = 18'sd25736;
	localparam logic signed [17:0] TWO_PI13 = 18'sd51472;
	localparam logic signed [CW-1:0] KINV30 = 48'sd652032874;

	typedef struct packed {
		logic start;
		logic rotate;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_cmd_t;

	typedef struct packed {
		logic done;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_rsp_t;

	function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0: v = 20'sd51472;
			5'd1: v = 20'sd30386;
			5'd2: v = 20'sd16055;
			5'd3: v = 20'sd8150;
			5'd4: v = 20'sd4091;
			5'd5: v = 20'sd2047;
			5'd6: v = 20'sd1024;
			5'd7: v = 20'sd512;
			5'd8: v = 20'sd256;
			5'd9: v = 20'sd128;
			5'd10: v = 20'sd64;
			5'd11: v = 20'sd32;
			5'd12: v = 20'sd16;
			5'd13: v = 20'sd8;
			5'd14: v = 20'sd4;
			5'd15: v = 20'sd2;
			5'd16: v = 20'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ----- sv/pure_pursuit_steering_unit.sv -----
// Pure pursuit steering unit.
// Input channel (in_valid/in_ready): opcode, pos_x, pos_y, heading. Opcode 0 clears the
// path, 1 appends a waypoint, 2 or 3 is a pose update. Every input beat yields exactly
// one output beat (out_valid/out_ready) with status, linear_speed, angular_speed and
// used_fallback.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 lookahead, 1 max linear
// speed, 2 max angular speed; index 3 is ignored. Write only while the unit is idle.
// Clear, append and empty-path pose go straight to the result stage. A pose walks the
// waypoint memory (one read port, registered read data) with read, difference, squares
// and compare steps per visited waypoint, then runs the shared CORDIC for vectoring
// (skipped at zero offset) and rotation, then a bit-serial divider unless lookahead is 0.
// One item is in flight at a time; the next input beat is taken as soon as the result
// has moved into the output register, even if the receiver stalls on it.
// Reset clears the waypoint count and loads the default config; memory contents are
// not cleared.
`default_nettype none
module pure_pursuit_steering_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [23:0] pos_x,
	input  wire logic signed [23:0] pos_y,
	input  wire logic signed [15:0] heading,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [14:0]             linear_speed,
	output logic signed [15:0]      angular_speed,
	output logic                    used_fallback,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [14:0]        cfg_data
);
	import ppst_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD = 4'd1;
	localparam logic [3:0] S_DIF = 4'd2;
	localparam logic [3:0] S_SQX = 4'd3;
	localparam logic [3:0] S_SQY = 4'd4;
	localparam logic [3:0] S_CMP = 4'd5;
	localparam logic [3:0] S_VEC = 4'd6;
	localparam logic [3:0] S_VRUN = 4'd7;
	localparam logic [3:0] S_WRAP = 4'd8;
	localparam logic [3:0] S_ROT = 4'd9;
	localparam logic [3:0] S_RRUN = 4'd10;
	localparam logic [3:0] S_MUL = 4'd11;
	localparam logic [3:0] S_DIVST = 4'd12;
	localparam logic [3:0] S_DRUN = 4'd13;
	localparam logic [3:0] S_FIN = 4'd14;

	logic [3:0]              state_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        idx_q;
	logic [14:0]             look_q;
	logic [14:0]             mlin_q;
	logic [14:0]             mang_q;
	logic [29:0]             l2_q;
	logic signed [23:0]      rx_q;
	logic signed [23:0]      ry_q;
	logic signed [15:0]      hd_q;
	logic signed [24:0]      dx_q;
	logic signed [24:0]      dy_q;
	logic [48:0]             sqx_q;
	logic [48:0]             sqy_q;
	logic                    fallback_q;
	logic signed [15:0]      ang13_q;
	logic signed [15:0]      alpha_q;
	logic                    neg_q;
	logic signed [31:0]      c_q;
	logic signed [31:0]      s_q;
	logic signed [47:0]      prod_q;
	logic signed [48:0]      num_q;
	logic [2:0]              res_status_q;
	logic [14:0]             res_lin_q;
	logic signed [15:0]      res_ang_q;
	logic                    res_fb_q;
	logic                    out_valid_q;
	logic [2:0]              out_status_q;
	logic [14:0]             out_lin_q;
	logic signed [15:0]      out_ang_q;
	logic                    out_fb_q;

	logic                    in_fire;
	logic                    wr_en;
	logic [23:0]             rd_x;
	logic [23:0]             rd_y;
	cordic_cmd_t             ccmd;
	cordic_rsp_t             crsp;
	logic                    div_start;
	logic [DVD_W-1:0]        div_dvd;
	logic                    div_done;
	logic [DVD_W-1:0]        div_quo;
	logic signed [49:0]      sq_sum;
	logic signed [ZW-1:0]    zr;
	logic signed [17:0]      a18;
	logic signed [ZW-1:0]    zrot;
	logic signed [47:0]      lin_full;
	logic [47:0]             num_abs;
	logic                    out_free;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign wr_en = in_fire && !opcode[1] && opcode[0]
		&& (count_q != CNT_W'(MAX_WAYPOINTS));
	assign out_free = !out_valid_q || out_ready;

	ppst_wp_mem u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wx    (pos_x),
		.wy    (pos_y),
		.raddr (idx_q),
		.rx    (rd_x),
		.ry    (rd_y)
	);

	ppst_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ccmd),
		.rsp    (crsp)
	);

	ppst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  ({look_q, 18'b0}),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		sq_sum = $signed({1'b0, sqx_q}) + $signed({1'b0, sqy_q});
		zr = (crsp.z + 20'sd4) >>> 3;
		a18 = 18'(ang13_q) - 18'(hd_q);
		zrot = ZW'(alpha_q) <<< 3;
		lin_full = (prod_q + 48'sd536870912) >>> 30;
		num_abs = num_q[48] ? 48'(-num_q) : 48'(num_q);
		div_dvd = num_abs + {16'b0, look_q, 17'b0};
		ccmd = '0;
		div_start = 1'b0;
		if (state_q == S_VEC && !(dx_q == 0 && dy_q == 0)) begin
			ccmd.start = 1'b1;
			ccmd.rotate = 1'b0;
			if (dx_q < 0) begin
				ccmd.x = -$signed({{3{dx_q[24]}}, dx_q, 20'b0});
				ccmd.y = -$signed({{3{dy_q[24]}}, dy_q, 20'b0});
				ccmd.z = (dy_q >= 0) ? PI16 : -PI16;
			end else begin
				ccmd.x = $signed({{3{dx_q[24]}}, dx_q, 20'b0});
				ccmd.y = $signed({{3{dy_q[24]}}, dy_q, 20'b0});
				ccmd.z = '0;
			end
		end
		if (state_q == S_ROT) begin
			ccmd.start = 1'b1;
			ccmd.rotate = 1'b1;
			ccmd.x = KINV30;
			ccmd.y = '0;
			if (zrot > HALF_PI16) begin
				ccmd.z = zrot - PI16;
			end else if (zrot < -HALF_PI16) begin
				ccmd.z = zrot + PI16;
			end else begin
				ccmd.z = zrot;
			end
		end
		if (state_q == S_DIVST && look_q != 15'd0) begin
			div_start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_q <= 15'd2458;
			mlin_q <= 15'd1229;
			mang_q <= 15'd3277;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOOKAHEAD: look_q <= cfg_data;
				CFG_MAX_LIN: mlin_q <= cfg_data;
				CFG_MAX_ANG: mang_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= (opcode[1] && count_q != '0) ? S_RD : S_FIN;
						if (!opcode[1]) begin
							if (opcode[0]) begin
								if (wr_en) begin
									count_q <= count_q + 1'b1;
								end
							end else begin
								count_q <= '0;
							end
						end
					end
				end
				S_RD: state_q <= S_DIF;
				S_DIF: state_q <= S_SQX;
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_CMP;
				S_CMP: begin
					if (sq_sum >= $signed({20'b0, l2_q})
						|| CNT_W'(idx_q) == count_q - 1'b1) begin
						state_q <= S_VEC;
					end else begin
						state_q <= S_RD;
					end
				end
				S_VEC: state_q <= (dx_q == 0 && dy_q == 0) ? S_WRAP : S_VRUN;
				S_VRUN: if (crsp.done) state_q <= S_WRAP;
				S_WRAP: state_q <= S_ROT;
				S_ROT: state_q <= S_RRUN;
				S_RRUN: if (crsp.done) state_q <= S_MUL;
				S_MUL: state_q <= S_DIVST;
				S_DIVST: state_q <= (look_q == 15'd0) ? S_FIN : S_DRUN;
				S_DRUN: if (div_done) state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rx_q <= pos_x;
				ry_q <= pos_y;
				hd_q <= heading;
				idx_q <= '0;
				l2_q <= look_q * look_q;
				res_lin_q <= '0;
				res_ang_q <= '0;
				res_fb_q <= 1'b0;
				if (opcode[1]) begin
					res_status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
				end else if (opcode[0]) begin
					res_status_q <= wr_en ? ST_STORED : ST_FULL;
				end else begin
					res_status_q <= ST_CLEARED;
				end
			end
			S_DIF: begin
				dx_q <= $signed({rd_x[23], rd_x}) - $signed({rx_q[23], rx_q});
				dy_q <= $signed({rd_y[23], rd_y}) - $signed({ry_q[23], ry_q});
			end
			S_SQX: sqx_q <= 49'(dx_q * dx_q);
			S_SQY: sqy_q <= 49'(dy_q * dy_q);
			S_CMP: begin
				fallback_q <= !(sq_sum >= $signed({20'b0, l2_q}));
				idx_q <= idx_q + 1'b1;
			end
			S_VEC: ang13_q <= '0;
			S_VRUN: begin
				if (crsp.done) begin
					if (zr > ZW'(PI13)) begin
						ang13_q <= 16'(PI13);
					end else if (zr < -ZW'(PI13)) begin
						ang13_q <= -16'(PI13);
					end else begin
						ang13_q <= zr[15:0];
					end
				end
			end
			S_WRAP: begin
				if (a18 > PI13) begin
					alpha_q <= 16'(a18 - TWO_PI13);
				end else if (a18 < -PI13) begin
					alpha_q <= 16'(a18 + TWO_PI13);
				end else begin
					alpha_q <= a18[15:0];
				end
			end
			S_ROT: neg_q <= (zrot > HALF_PI16) || (zrot < -HALF_PI16);
			S_RRUN: begin
				c_q <= neg_q ? 32'(-crsp.x) : 32'(crsp.x);
				s_q <= neg_q ? 32'(-crsp.y) : 32'(crsp.y);
			end
			S_MUL: begin
				prod_q <= 48'($signed({1'b0, mlin_q}) * c_q);
				num_q <= 49'($signed({1'b0, mlin_q, 1'b0}) * s_q);
			end
			S_DIVST: begin
				res_fb_q <= fallback_q;
				if (c_q <= 0) begin
					res_lin_q <= '0;
				end else if (lin_full > 48'sd32767) begin
					res_lin_q <= 15'h7FFF;
				end else begin
					res_lin_q <= lin_full[14:0];
				end
				if (look_q == 15'd0) begin
					if (s_q > 0) begin
						res_ang_q <= $signed({1'b0, mang_q});
					end else if (s_q < 0) begin
						res_ang_q <= -$signed({1'b0, mang_q});
					end else begin
						res_ang_q <= '0;
					end
				end
			end
			S_DRUN: begin
				if (div_done) begin
					if (div_quo > {33'b0, mang_q}) begin
						res_ang_q <= num_q[48] ? -$signed({1'b0, mang_q})
							: $signed({1'b0, mang_q});
					end else begin
						res_ang_q <= num_q[48] ? -$signed({1'b0, div_quo[14:0]})
							: $signed({1'b0, div_quo[14:0]});
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_lin_q <= res_lin_q;
					out_ang_q <= res_ang_q;
					out_fb_q <= res_fb_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign linear_speed = out_lin_q;
	assign angular_speed = out_ang_q;
	assign used_fallback = out_fb_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_WAYPOINTS))
		else $error("waypoint count beyond capacity");

	a_idle_speeds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_OK |->
		out_lin_q == '0 && out_ang_q == '0 && !out_fb_q)
		else $error("nonzero command on non-pose status");

	a_ang_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == ST_OK |->
		out_ang_q <= $signed({1'b0, mang_q}) && out_ang_q >= -$signed({1'b0, mang_q}))
		else $error("angular speed beyond limit");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> CNT_W'(idx_q) < count_q)
		else $error("read beyond stored path");
endmodule
`default_nettype wire

// ----- sv/ppst_wp_mem.sv -----
`default_nettype none
module ppst_wp_mem (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [ppst_pkg::IDX_W-1:0] waddr,
	input  wire logic [23:0]                wx,
	input  wire logic [23:0]                wy,
	input  wire logic [ppst_pkg::IDX_W-1:0] raddr,
	output logic [23:0]                     rx,
	output logic [23:0]                     ry
);
	import ppst_pkg::*;

	logic [47:0] mem [MAX_WAYPOINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wx, wy};
		end
		{rx, ry} <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/ppst_cordic.sv -----
`default_nettype none
module ppst_cordic (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ppst_pkg::cordic_cmd_t cmd,
	output ppst_pkg::cordic_rsp_t      rsp
);
	import ppst_pkg::*;

	logic                 active_q;
	logic                 rotate_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [CW-1:0] t;
	logic signed [CW-1:0] u;
	logic signed [ZW-1:0] a;
	logic                 d;

	always_comb begin
		t = y_q >>> step_q;
		u = x_q >>> step_q;
		a = atan_val(5'(step_q));
		d = rotate_q ? (z_q >= 0) : (y_q < 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				active_q <= 1'b1;
				step_q <= '0;
			end else if (active_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					active_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rotate_q <= cmd.rotate;
			x_q <= cmd.x;
			y_q <= cmd.y;
			z_q <= cmd.z;
		end else if (active_q) begin
			if (d) begin
				x_q <= x_q - t;
				y_q <= y_q + u;
				z_q <= z_q - a;
			end else begin
				x_q <= x_q + t;
				y_q <= y_q - u;
				z_q <= z_q + a;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.x = x_q;
	assign rsp.y = y_q;
	assign rsp.z = z_q;
endmodule
`default_nettype wire

// ----- sv/ppst_div.sv -----
`default_nettype none
module ppst_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [ppst_pkg::DVD_W-1:0] dividend,
	input  wire logic [ppst_pkg::DVS_W-1:0] divisor,
	output logic                            done,
	output logic [ppst_pkg::DVD_W-1:0]      quotient
);
	import ppst_pkg::*;

	localparam int CNT_DW = $clog2(DVD_W);

	logic              active_q;
	logic              done_q;
	logic [CNT_DW-1:0] cnt_q;
	logic [DVS_W:0]    rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W:0]    trial;
	logic              fits;

	always_comb begin
		trial = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
		fits = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_DW'(DVD_W - 1)) begin
					active_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (active_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ----- verif/tb_pure_pursuit_steering_unit.sv -----
`default_nettype none
module tb_pure_pursuit_steering_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ppst_pkg::*;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_POSE = 2'd2;
	localparam logic [1:0] OP_POSE_ALT = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int HEAD_PI = 25736;
	localparam int ITEMS_TARGET = 800;

	typedef struct packed {
		logic [2:0] status;
		logic [14:0] linear_speed;
		logic signed [15:0] angular_speed;
		logic used_fallback;
	} steer_cmd_t;

	class steer_scoreboard;
		logic signed [23:0] wx[MAX_WAYPOINTS];
		logic signed [23:0] wy[MAX_WAYPOINTS];
		int unsigned count;
		logic [14:0] look, vmax, wmax;
		steer_cmd_t pending[$];
		int errors;
		longint arctab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};

		function new();
			count = 0;
			look = 15'd2458;
			vmax = 15'd1229;
			wmax = 15'd3277;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [14:0] v);
			case (idx)
				CFG_LOOKAHEAD: look = v;
				CFG_MAX_LIN: vmax = v;
				CFG_MAX_ANG: wmax = v;
				default: ;
			endcase
		endfunction

		function longint bearing_q13(longint dx, longint dy);
			longint x, y, z, t, u;
			z = 0;
			if (dx == 0 && dy == 0) return 0;
			x = dx * (longint'(1) << 20);
			y = dy * (longint'(1) << 20);
			if (x < 0) begin
				x = -x;
				y = -y;
				z = (dy >= 0) ? 205887 : -205887;
			end
			for (int i = 0; i < CORDIC_STEPS && i < 16; i++) begin
				t = y >>> i;
				u = x >>> i;
				if (y >= 0) begin
					x += t; y -= u; z += arctab[i];
				end else begin
					x -= t; y += u; z -= arctab[i];
				end
			end
			z = (z + 4) >>> 3;
			if (z > HEAD_PI) z = HEAD_PI;
			if (z < -HEAD_PI) z = -HEAD_PI;
			return z;
		endfunction

		function void rotate_unit(input longint a13, output longint c, output longint s);
			longint z, x, y, t, u;
			bit neg;
			z = a13 * 8;
			x = 652032874;
			y = 0;
			neg = 0;
			if (z > 102944) begin
				z -= 205887; neg = 1;
			end else if (z < -102944) begin
				z += 205887; neg = 1;
			end
			for (int i = 0; i < CORDIC_STEPS && i < 16; i++) begin
				t = y >>> i;
				u = x >>> i;
				if (z >= 0) begin
					x -= t; y += u; z -= arctab[i];
				end else begin
					x += t; y -= u; z += arctab[i];
				end
			end
			if (neg) begin
				x = -x; y = -y;
			end
			c = x;
			s = y;
		endfunction

		function void note_input(logic [1:0] op, logic signed [23:0] px,
				logic signed [23:0] py, logic signed [15:0] hd);
			steer_cmd_t r;
			longint rx, ry, tx, ty, ddx, ddy, l2, alpha, c, s, lin, ang, num, den, mag;
			bit found;
			r = '0;
			found = 0;
			if (op == OP_CLEAR) begin
				count = 0;
				r.status = ST_CLEARED;
			end else if (op == OP_APPEND) begin
				if (count < MAX_WAYPOINTS) begin
					wx[count] = px;
					wy[count] = py;
					count++;
					r.status = ST_STORED;
				end else begin
					r.status = ST_FULL;
				end
			end else if (count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				rx = px;
				ry = py;
				l2 = longint'(look) * longint'(look);
				tx = wx[count-1];
				ty = wy[count-1];
				for (int i = 0; i < count; i++) begin
					if (!found) begin
						ddx = longint'(wx[i]) - rx;
						ddy = longint'(wy[i]) - ry;
						if (ddx * ddx + ddy * ddy >= l2) begin
							tx = wx[i];
							ty = wy[i];
							found = 1;
						end
					end
				end
				alpha = bearing_q13(tx - rx, ty - ry) - longint'(hd);
				if (alpha > HEAD_PI) alpha -= 2 * HEAD_PI;
				if (alpha < -HEAD_PI) alpha += 2 * HEAD_PI;
				rotate_unit(alpha, c, s);
				if (c <= 0) begin
					lin = 0;
				end else begin
					lin = (longint'(vmax) * c + (longint'(1) << 29)) >>> 30;
					if (lin > 32767) lin = 32767;
				end
				num = 2 * longint'(vmax) * s;
				if (look == 0) begin
					ang = (s > 0) ? longint'(wmax) : ((s < 0) ? -longint'(wmax) : 0);
				end else begin
					den = longint'(look) << 18;
					mag = ((num < 0 ? -num : num) + den / 2) / den;
					ang = (num < 0) ? -mag : mag;
					if (ang > longint'(wmax)) ang = wmax;
					if (ang < -longint'(wmax)) ang = -longint'(wmax);
				end
				r.status = ST_OK;
				r.linear_speed = lin[14:0];
				r.angular_speed = ang[15:0];
				r.used_fallback = !found;
			end
			pending.push_back(r);
		endfunction

		function void check_result(steer_cmd_t got);
			steer_cmd_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: output beat with nothing pending: %p", $realtime, got);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status || got.linear_speed !== want.linear_speed ||
					got.angular_speed !== want.angular_speed ||
					got.used_fallback !== want.used_fallback) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch status %0d/%0d lin %0d/%0d ang %0d/%0d fb %0d/%0d",
						$realtime, want.status, got.status, want.linear_speed,
						got.linear_speed, want.angular_speed, got.angular_speed,
						want.used_fallback, got.used_fallback);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] opcode = '0;
	logic signed [23:0] pos_x = '0;
	logic signed [23:0] pos_y = '0;
	logic signed [15:0] heading = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [2:0] status;
	logic [14:0] linear_speed;
	logic signed [15:0] angular_speed;
	logic used_fallback;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [14:0] cfg_data = '0;

	steer_scoreboard sb = new();
	int items = 0;
	int send_idle = 7;
	int recv_idle = 46;
	bit hold_req = 0;
	bit hold_done = 0;
	int hold_cnt = 0;

	pure_pursuit_steering_unit DUT (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_input(opcode, pos_x, pos_y, heading);
		if (arst_n && cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
		if (arst_n && out_valid && out_ready)
			sb.check_result({status, linear_speed, angular_speed, used_fallback});
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = 2000;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			out_ready = 0;
			hold_cnt--;
		end else begin
			out_ready = ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_item(input logic [1:0] op, input logic signed [23:0] x,
			input logic signed [23:0] y, input logic signed [15:0] h);
		if (items < ITEMS_TARGET / 3) begin
			send_idle = 7; recv_idle = 46;
		end else if (items < 2 * ITEMS_TARGET / 3) begin
			send_idle = 46; recv_idle = 7;
		end else begin
			send_idle = 0; recv_idle = 0;
			if (!hold_done) begin
				hold_req = 1;
				hold_done = 1;
			end
		end
		while ($urandom_range(99) < send_idle) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		opcode = op;
		pos_x = x;
		pos_y = y;
		heading = h;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		items++;
	endtask

	task automatic drain;
		in_valid = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] v);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_all(input logic [14:0] l, input logic [14:0] v, input logic [14:0] w);
		drain();
		write_reg(CFG_LOOKAHEAD, l);
		write_reg(CFG_MAX_LIN, v);
		write_reg(CFG_MAX_ANG, w);
	endtask

	function automatic logic signed [23:0] near(input logic signed [23:0] c, input int bits);
		longint v;
		v = longint'(c) + longint'($urandom_range(0, (1 << bits) - 1)) - (longint'(1) << (bits - 1));
		return v[23:0];
	endfunction

	function automatic logic signed [15:0] rand_heading();
		int v;
		v = $urandom_range(0, 2 * HEAD_PI) - HEAD_PI;
		return v[15:0];
	endfunction

	task automatic run_path(input int n, input int npose);
		logic signed [23:0] cx, cy;
		int spread;
		cx = near(0, 24);
		cy = near(0, 24);
		spread = $urandom_range(12, 16);
		send_item(OP_CLEAR, near(0, 24), near(0, 24), rand_heading());
		for (int i = 0; i < n; i++) send_item(OP_APPEND, near(cx, spread), near(cy, spread),
			rand_heading());
		for (int i = 0; i < npose; i++) begin
			send_item($urandom_range(1) ? OP_POSE : OP_POSE_ALT, near(cx, spread),
				near(cy, spread), rand_heading());
			if ($urandom_range(3) == 0)
				send_item(OP_APPEND, near(cx, spread), near(cy, spread), rand_heading());
		end
	endtask

	task automatic run_phase(input int quota);
		int start;
		start = items;
		while (items - start < quota) begin
			if ($urandom_range(9) == 0)
				send_item(2'($urandom_range(3)), near(0, 24), near(0, 24), rand_heading());
			else
				run_path($urandom_range(1, 12), $urandom_range(1, 6));
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_item(OP_POSE, 24'sd0, 24'sd0, 16'sd0);
		send_item(OP_CLEAR, 24'sd0, 24'sd0, 16'sd0);
		send_item(OP_APPEND, 24'sd8388607, -24'sd8388608, 16'sd0);
		send_item(OP_APPEND, -24'sd8388608, 24'sd8388607, 16'sd0);
		send_item(OP_APPEND, 24'sd0, 24'sd0, 16'sd0);
		send_item(OP_POSE, 24'sd0, 24'sd0, 16'sd25736);
		send_item(OP_POSE_ALT, 24'sd0, 24'sd0, -16'sd25736);
		send_item(OP_POSE, 24'sd8388607, 24'sd8388607, -16'sd25736);
		send_item(OP_POSE, -24'sd8388608, -24'sd8388608, 16'sd12345);
		send_item(OP_CLEAR, -24'sd1, -24'sd1, -16'sd1);
		send_item(OP_POSE_ALT, 24'sd5, 24'sd5, 16'sd0);
		send_item(OP_APPEND, 24'sd100, 24'sd200, 16'sd0);
		send_item(OP_POSE, 24'sd100, 24'sd200, 16'sd0);
		send_item(OP_APPEND, 24'sd16384, 24'sd0, 16'sd0);
		send_item(OP_POSE_ALT, 24'sd0, 24'sd0, 16'sd0);
		send_item(OP_POSE, 24'sd0, 24'sd0, 16'sd12868);
		send_item(OP_POSE, 24'sd20000, -24'sd3000, -16'sd12868);
		send_item(OP_POSE, -24'sd5555, 24'sd4444, 16'sd25735);

		set_all(15'd41, 15'd0, 15'd0);
		send_item(OP_CLEAR, 24'sd0, 24'sd0, 16'sd0);
		for (int i = 0; i < MAX_WAYPOINTS + 2; i++)
			send_item(OP_APPEND, near(0, 14), near(0, 14), rand_heading());
		for (int i = 0; i < 3; i++) send_item(OP_POSE, near(0, 14), near(0, 14), rand_heading());

		set_all(15'd32767, 15'd32767, 15'd32767);
		run_phase(110);
		set_all(15'd0, 15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)));
		run_phase(90);
		set_all(15'($urandom_range(41, 32767)), 15'($urandom_range(0, 32767)),
			15'($urandom_range(0, 32767)));
		run_phase(90);
		set_all(15'd41, 15'd32767, 15'd0);
		run_phase(60);
		drain();
		write_reg(CFG_UNUSED, 15'($urandom_range(0, 32767)));
		set_all(15'd2458, 15'd1229, 15'd3277);
		run_phase(90);
		set_all(15'($urandom_range(41, 8000)), 15'($urandom_range(0, 32767)),
			15'($urandom_range(0, 32767)));
		run_phase(90);
		in_valid = 0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (sb.pending.size() != 0) begin
			sb.errors++;
			$display("%0d results never arrived", sb.pending.size());
		end
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
